// ===== sv/cpba_pkg.sv =====
`default_nettype none

package cpba_pkg;

  localparam int MAP_PAGES = 1024;
  localparam int PAGE_W    = $clog2(MAP_PAGES);
  localparam int WORD_W    = (MAP_PAGES < 32) ? MAP_PAGES : 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = MAP_PAGES / WORD_W;
  localparam int WADDR_W   = (PAGE_W - BIT_W > 0) ? PAGE_W - BIT_W : 1;
  // holds a page count, a run length and start + count of a release
  localparam int CMP_W     = (PAGE_W + 1 > 12) ? PAGE_W + 1 : 12;

  localparam int START_W   = 10;
  localparam int COUNT_W   = 11;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADARG  = 2'd2,
    ST_NOTUSED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_BITS,
    S_MARK_RD,
    S_MARK_WR,
    S_CHK_RD,
    S_CHK_EV,
    S_CLR_RD,
    S_CLR_WR,
    S_DONE
  } state_t;

  // Map row contents after reset: page zero reserved
  function automatic logic [WORD_W-1:0] row_reset(input logic [WADDR_W-1:0] row);
    logic [WORD_W-1:0] r;
    r = '0;
    if (row == '0) begin
      r[0] = 1'b1;
    end
    return r;
  endfunction

  // Ones from bit lo up to bit hi inclusive
  function automatic logic [WORD_W-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                   input logic [BIT_W-1:0] hi);
    logic [WORD_W-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (BIT_W'(WORD_W - 1) - hi));
  endfunction

endpackage

`default_nettype wire

// ===== sv/cpba_req_if.sv =====
`default_nettype none

interface cpba_req_if;
  import cpba_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [START_W-1:0] start_page;
  logic [COUNT_W-1:0] page_count;

  modport source (output valid, action, start_page, page_count, input ready);
  modport sink   (input valid, action, start_page, page_count, output ready);
endinterface

`default_nettype wire

// ===== sv/cpba_rsp_if.sv =====
`default_nettype none

interface cpba_rsp_if;
  import cpba_pkg::*;

  logic               valid;
  logic               ready;
  logic [START_W-1:0] run_start;
  logic [1:0]         status;

  modport source (output valid, run_start, status, input ready);
  modport sink   (input valid, run_start, status, output ready);
endinterface

`default_nettype wire

// ===== sv/cpba_ram.sv =====
`default_nettype none

module cpba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/contiguous_page_bitmap_allocator_unit.sv =====
// Channel  Dir  Payload                                Transaction
// req      in   action, start_page[9:0], page_count    req.valid && req.ready
// rsp      out  run_start[9:0], status[1:0]            rsp.valid && rsp.ready
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Allocate walks the map one 32-bit row at a time: fully used rows and free
// rows short of the run are skipped whole, other rows go one page a cycle,
// then the rows of the run are marked. Free checks every row of the range,
// then clears them. Bad arguments go straight to the result.
// Reset is synchronous; per-row valid bits stand for the reset map, no clearing
// pass. The result register lets the next request in while rsp is stalled.
`default_nettype none

module contiguous_page_bitmap_allocator_unit
  import cpba_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  cpba_req_if.sink   req,
  cpba_rsp_if.source rsp
);

  state_t state, state_next;

  logic [WADDR_W-1:0]   w, w_next;
  logic [BIT_W-1:0]     b, b_next;
  logic [CMP_W-1:0]     run, run_next;
  logic [CMP_W-1:0]     count, count_next;
  logic [PAGE_W-1:0]    first, first_next;
  logic [PAGE_W-1:0]    lo_page, lo_page_next;
  logic [PAGE_W-1:0]    hi_page, hi_page_next;
  logic [WORD_W-1:0]    word, word_next;
  logic [START_W-1:0]   res_start, res_start_next;
  status_t              res_status, res_status_next;
  logic [NUM_WORDS-1:0] row_valid;

  logic                 out_valid;
  logic [START_W-1:0]   out_start;
  status_t              out_status;
  logic                 out_load;

  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  logic [WORD_W-1:0]    eff;
  logic [WORD_W-1:0]    mask;
  logic [WADDR_W-1:0]   lo_word, hi_word;
  logic [BIT_W-1:0]     lo_bit, hi_bit;
  logic                 last_row;
  logic [PAGE_W-1:0]    cur_page;
  logic [PAGE_W-1:0]    run_first;
  logic [CMP_W-1:0]     req_count, req_start, req_end;
  logic [CMP_W-1:0]     run_inc, run_row;

  cpba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w),
    .wdata (ram_wdata),
    .raddr (w),
    .rdata (ram_rdata)
  );

  // Row w was read in the previous cycle; unwritten rows read as reset value
  assign eff      = row_valid[w] ? ram_rdata : row_reset(w);
  assign lo_word  = WADDR_W'(lo_page >> BIT_W);
  assign hi_word  = WADDR_W'(hi_page >> BIT_W);
  assign lo_bit   = (w == lo_word) ? lo_page[BIT_W-1:0] : '0;
  assign hi_bit   = (w == hi_word) ? hi_page[BIT_W-1:0] : '1;
  assign mask     = range_mask(lo_bit, hi_bit);
  assign last_row = (w == WADDR_W'(NUM_WORDS - 1));
  assign cur_page = PAGE_W'({w, b});
  assign run_first = (run == '0) ? cur_page : first;
  assign run_inc  = run + CMP_W'(1);
  assign run_row  = run + CMP_W'(WORD_W);

  assign req_count = CMP_W'(req.page_count);
  assign req_start = CMP_W'(req.start_page);
  assign req_end   = req_start + req_count;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.run_start = out_start;
  assign rsp.status    = out_status;
  assign out_load      = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next      = state;
    w_next          = w;
    b_next          = b;
    run_next        = run;
    count_next      = count;
    first_next      = first;
    lo_page_next    = lo_page;
    hi_page_next    = hi_page;
    word_next       = word;
    res_start_next  = res_start;
    res_status_next = res_status;
    ram_we          = 1'b0;
    ram_wdata       = eff | mask;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          count_next     = req_count;
          res_start_next = '0;
          run_next       = '0;
          w_next         = '0;
          if (req.action == ACT_ALLOC) begin
            if (req_count == '0 || req_count > CMP_W'(MAP_PAGES)) begin
              res_status_next = ST_BADARG;
              state_next      = S_DONE;
            end else begin
              state_next = S_SCAN_RD;
            end
          end else begin
            if (req_count == '0 || req_start == '0 || req_end > CMP_W'(MAP_PAGES)) begin
              res_status_next = ST_BADARG;
              state_next      = S_DONE;
            end else begin
              lo_page_next = PAGE_W'(req.start_page);
              hi_page_next = PAGE_W'(req_end - CMP_W'(1));
              w_next       = WADDR_W'(PAGE_W'(req.start_page) >> BIT_W);
              state_next   = S_CHK_RD;
            end
          end
        end
      end

      S_SCAN_RD: begin
        state_next = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        word_next = eff;
        b_next    = '0;
        if (eff == '1 || (eff == '0 && run_row < count)) begin
          // whole row settles the run: all used breaks it, all free extends it
          if (eff == '1) begin
            run_next = '0;
          end else begin
            if (run == '0) begin
              first_next = PAGE_W'({w, {BIT_W{1'b0}}});
            end
            run_next = run_row;
          end
          if (last_row) begin
            res_status_next = ST_NOSPACE;
            state_next      = S_DONE;
          end else begin
            w_next     = w + WADDR_W'(1);
            state_next = S_SCAN_RD;
          end
        end else begin
          state_next = S_BITS;
        end
      end

      S_BITS: begin
        if (!word[b] && run_inc == count) begin
          lo_page_next    = run_first;
          hi_page_next    = cur_page;
          w_next          = WADDR_W'(run_first >> BIT_W);
          res_start_next  = START_W'(run_first);
          res_status_next = ST_OK;
          state_next      = S_MARK_RD;
        end else begin
          if (word[b]) begin
            run_next = '0;
          end else begin
            first_next = run_first;
            run_next   = run_inc;
          end
          if (b == '1) begin
            if (last_row) begin
              res_status_next = ST_NOSPACE;
              state_next      = S_DONE;
            end else begin
              w_next     = w + WADDR_W'(1);
              state_next = S_SCAN_RD;
            end
          end else begin
            b_next = b + BIT_W'(1);
          end
        end
      end

      S_MARK_RD: begin
        state_next = S_MARK_WR;
      end

      S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = eff | mask;
        if (w == hi_word) begin
          state_next = S_DONE;
        end else begin
          w_next     = w + WADDR_W'(1);
          state_next = S_MARK_RD;
        end
      end

      S_CHK_RD: begin
        state_next = S_CHK_EV;
      end

      S_CHK_EV: begin
        if ((eff & mask) != mask) begin
          res_status_next = ST_NOTUSED;
          state_next      = S_DONE;
        end else if (w == hi_word) begin
          w_next     = lo_word;
          state_next = S_CLR_RD;
        end else begin
          w_next     = w + WADDR_W'(1);
          state_next = S_CHK_RD;
        end
      end

      S_CLR_RD: begin
        state_next = S_CLR_WR;
      end

      S_CLR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = eff & ~mask;
        if (w == hi_word) begin
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end else begin
          w_next     = w + WADDR_W'(1);
          state_next = S_CLR_RD;
        end
      end

      S_DONE: begin
        // hold until the result register frees up
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[w] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    w          <= w_next;
    b          <= b_next;
    run        <= run_next;
    count      <= count_next;
    first      <= first_next;
    lo_page    <= lo_page_next;
    hi_page    <= hi_page_next;
    word       <= word_next;
    res_start  <= res_start_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_start  <= res_start;
      out_status <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cpba_pkg::*;

  localparam int RANDOM_REQUESTS = 1526;
  localparam int LONG_HOLD       = 400;
  // slowest allocate walks every row page by page
  localparam int DRAIN_CYCLES    = 1200;

  typedef struct {
    logic [START_W-1:0] run_start;
    status_t            status;
  } page_result_t;

  typedef struct {
    logic    act;
    int      first_page;
    int      pages;
    bit      fixed;
    int      exp_start;
    status_t exp_status;
  } request_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpba_req_if req_ch();
  cpba_rsp_if rsp_ch();

  contiguous_page_bitmap_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #6 clk = ~clk;

  logic [MAP_PAGES-1:0] page_used;
  page_result_t         pending_results[$];
  int                   error_count = 0;
  bit                   quiet_stretch = 1'b0;
  bit                   long_hold_pending = 1'b0;

  request_row_t directed_rows[24] = '{
    '{ACT_ALLOC,    0,    0, 1, 0, ST_BADARG},
    '{ACT_FREE,     5,    0, 1, 0, ST_BADARG},
    '{ACT_ALLOC, 1023, 1025, 1, 0, ST_BADARG},
    '{ACT_ALLOC,    0, 2047, 1, 0, ST_BADARG},
    '{ACT_FREE,     0,    1, 1, 0, ST_BADARG},
    '{ACT_FREE,  1023,    2, 1, 0, ST_BADARG},
    '{ACT_FREE,  1023, 2047, 1, 0, ST_BADARG},
    '{ACT_FREE,    10,    4, 1, 0, ST_NOTUSED},
    '{ACT_ALLOC,    0,    1, 1, 1, ST_OK},
    '{ACT_ALLOC,    0, 1024, 1, 0, ST_NOSPACE},
    '{ACT_ALLOC,  777, 1022, 0, 0, ST_OK},
    '{ACT_ALLOC,    0,    1, 0, 0, ST_OK},
    '{ACT_FREE,     1, 1023, 0, 0, ST_OK},
    '{ACT_ALLOC,    0, 1023, 0, 0, ST_OK},
    '{ACT_FREE,  1023,    1, 0, 0, ST_OK},
    '{ACT_FREE,  1023,    1, 0, 0, ST_OK},
    '{ACT_FREE,   512,  512, 0, 0, ST_OK},
    '{ACT_FREE,     1, 1022, 0, 0, ST_OK},
    '{ACT_ALLOC,    0,    5, 0, 0, ST_OK},
    '{ACT_ALLOC,    0,    3, 0, 0, ST_OK},
    '{ACT_FREE,     2,    2, 0, 0, ST_OK},
    '{ACT_ALLOC,    0,    3, 0, 0, ST_OK},
    '{ACT_ALLOC,    0,    2, 0, 0, ST_OK},
    '{ACT_FREE,     1,   11, 0, 0, ST_OK}
  };

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  function automatic int draw_idle();
    return quiet_stretch ? 0 : $urandom_range(0, 14);
  endfunction

  // First-fit allocate or checked release against the local page map
  function automatic page_result_t apply_request(input logic act,
                                                 input logic [START_W-1:0] first_page,
                                                 input logic [COUNT_W-1:0] pages);
    page_result_t res;
    int           run_len;
    int           run_first;
    res.run_start = '0;
    res.status    = ST_OK;
    if (act == ACT_ALLOC) begin
      if (pages == 0 || pages > MAP_PAGES) begin
        res.status = ST_BADARG;
        return res;
      end
      run_len   = 0;
      run_first = 0;
      for (int p = 0; p < MAP_PAGES; p++) begin
        if (page_used[p]) begin
          run_len = 0;
        end else begin
          if (run_len == 0) run_first = p;
          run_len++;
          if (run_len == int'(pages)) begin
            for (int k = run_first; k <= p; k++) page_used[k] = 1'b1;
            res.run_start = START_W'(run_first);
            return res;
          end
        end
      end
      res.status = ST_NOSPACE;
      return res;
    end
    if (pages == 0 || first_page == 0 || int'(first_page) + int'(pages) > MAP_PAGES) begin
      res.status = ST_BADARG;
      return res;
    end
    for (int k = int'(first_page); k < int'(first_page) + int'(pages); k++) begin
      if (!page_used[k]) begin
        res.status = ST_NOTUSED;
        return res;
      end
    end
    for (int k = int'(first_page); k < int'(first_page) + int'(pages); k++) page_used[k] = 1'b0;
    return res;
  endfunction

  // Find a block of used pages (never page zero), starting from a random page
  function automatic bit find_used_block(output int block_at, output int block_len);
    int offset;
    int p;
    offset    = $urandom_range(0, MAP_PAGES - 2);
    block_at  = 0;
    block_len = 0;
    for (int i = 0; i < MAP_PAGES - 1; i++) begin
      p = 1 + (offset + i) % (MAP_PAGES - 1);
      if (page_used[p]) begin
        block_at = p;
        while (block_at > 1 && page_used[block_at - 1]) block_at--;
        while (block_at + block_len < MAP_PAGES && page_used[block_at + block_len]) block_len++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic send_request(input logic act, input logic [START_W-1:0] first_page,
                              input logic [COUNT_W-1:0] pages, input bit use_fixed,
                              input page_result_t fixed_res);
    int           gap;
    page_result_t predicted;
    gap = draw_idle();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.start_page <= first_page;
    req_ch.page_count <= pages;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(act, first_page, pages);
    pending_results.push_back(use_fixed ? fixed_res : predicted);
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Response side: random stalls, plus a long hold-off whenever req_side asks for one
  initial begin : rsp_side
    int           stall_left;
    page_result_t want;
    stall_left   = 0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected response run_start=%0d status=%0d",
                                    rsp_ch.run_start, rsp_ch.status));
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.run_start !== want.run_start)
            report_mismatch($sformatf("run_start %0d, want %0d", rsp_ch.run_start,
                                      want.run_start));
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, want %s", rsp_ch.status,
                                      want.status.name()));
        end
        stall_left = long_hold_pending ? LONG_HOLD : draw_idle();
        long_hold_pending = 1'b0;
        if (stall_left > 0) rsp_ch.ready <= 1'b0;
      end else if (!rsp_ch.ready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : req_side
    logic [START_W-1:0] first_page;
    logic [COUNT_W-1:0] pages;
    logic               act;
    page_result_t       fixed_res;
    int                 pick;
    int                 size_pick;
    int                 block_at;
    int                 block_len;
    int                 skip;
    bit                 filling;
    filling           = 1'b0;
    page_used         = '0;
    page_used[0]      = 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_ALLOC;
    req_ch.start_page <= '0;
    req_ch.page_count <= '0;
    rst               <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      fixed_res.run_start = START_W'(directed_rows[i].exp_start);
      fixed_res.status    = directed_rows[i].exp_status;
      send_request(directed_rows[i].act, START_W'(directed_rows[i].first_page),
                   COUNT_W'(directed_rows[i].pages), directed_rows[i].fixed, fixed_res);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // alternate between filling the map and draining it
      if (n % 150 == 0) filling = ~filling;
      if (n % 100 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      if (n == 300 || n == 1100) long_hold_pending = 1'b1;
      if (n == 700) wait_all_results();

      pick       = $urandom_range(0, 99);
      act        = ACT_ALLOC;
      first_page = START_W'($urandom());
      size_pick  = $urandom_range(0, 19);
      if (size_pick < 15) pages = COUNT_W'($urandom_range(1, 16));
      else if (size_pick < 19) pages = COUNT_W'($urandom_range(17, 128));
      else pages = COUNT_W'($urandom_range(129, MAP_PAGES));

      if (pick < 8) begin
        act   = 1'($urandom_range(0, 1));
        pages = COUNT_W'($urandom());
      end else if (pick >= (filling ? 68 : 35) && find_used_block(block_at, block_len)) begin
        act = ACT_FREE;
        if ($urandom_range(0, 2) == 0) begin
          skip      = $urandom_range(0, block_len - 1);
          block_at  += skip;
          block_len -= skip;
        end
        first_page = START_W'(block_at);
        pages      = COUNT_W'($urandom_range(1, block_len));
        // overrun into a free page or past the end of the map
        if ($urandom_range(0, 6) == 0) pages = COUNT_W'(block_len + $urandom_range(1, 6));
      end
      send_request(act, first_page, pages, 1'b0, fixed_res);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #96000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cpba_pkg.sv
sv/cpba_req_if.sv
sv/cpba_rsp_if.sv
sv/cpba_ram.sv
sv/contiguous_page_bitmap_allocator_unit.sv
dv/tb_top.sv
